// File: rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Shared types, token codes, limits and the reserved word table.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int unsigned ID_MAX_LEN        = 32;
    localparam int unsigned COMMENT_DEPTH_MAX = 16;
    localparam int unsigned STORE_DEPTH       = 32;
    localparam int unsigned ID_LIMIT =
        (ID_MAX_LEN < STORE_DEPTH) ? ID_MAX_LEN : STORE_DEPTH;
    localparam int unsigned NUM_KW = 26;

    // Token kinds.
    localparam logic [5:0] K_EOF     = 6'd0;
    localparam logic [5:0] K_IDENT   = 6'd1;
    localparam logic [5:0] K_NUMBER  = 6'd2;
    localparam logic [5:0] K_STRING  = 6'd3;
    localparam logic [5:0] K_ERROR   = 6'd4;
    localparam logic [5:0] K_LPAREN  = 6'd5;
    localparam logic [5:0] K_RPAREN  = 6'd6;
    localparam logic [5:0] K_STAR    = 6'd7;
    localparam logic [5:0] K_PLUS    = 6'd8;
    localparam logic [5:0] K_COMMA   = 6'd9;
    localparam logic [5:0] K_MINUS   = 6'd10;
    localparam logic [5:0] K_DOT     = 6'd11;
    localparam logic [5:0] K_SLASH   = 6'd12;
    localparam logic [5:0] K_BECOMES = 6'd13;
    localparam logic [5:0] K_SEMI    = 6'd14;
    localparam logic [5:0] K_LT      = 6'd15;
    localparam logic [5:0] K_LE      = 6'd16;
    localparam logic [5:0] K_NE      = 6'd17;
    localparam logic [5:0] K_EQ      = 6'd18;
    localparam logic [5:0] K_GT      = 6'd19;
    localparam logic [5:0] K_GE      = 6'd20;
    localparam logic [5:0] K_LBRACK  = 6'd21;
    localparam logic [5:0] K_RBRACK  = 6'd22;
    localparam logic [5:0] K_KW_BASE = 6'd23;

    // Error codes.
    localparam logic [3:0] E_NONE    = 4'd0;
    localparam logic [3:0] E_ILLEGAL = 4'd1;
    localparam logic [3:0] E_NUMBER  = 4'd2;
    localparam logic [3:0] E_IDLONG  = 4'd3;
    localparam logic [3:0] E_STROPEN = 4'd4;
    localparam logic [3:0] E_NONPRT  = 4'd5;
    localparam logic [3:0] E_ESCAPE  = 4'd6;
    localparam logic [3:0] E_COMOPEN = 4'd7;
    localparam logic [3:0] E_NESTING = 4'd8;

    // Output register source selects.
    localparam logic [1:0] LD_NONE = 2'd0;
    localparam logic [1:0] LD_RUN  = 2'd1;
    localparam logic [1:0] LD_A    = 2'd2;
    localparam logic [1:0] LD_B    = 2'd3;

    typedef struct packed {
        logic [5:0]  kind;
        logic [3:0]  err;
        logic [30:0] num;
        logic [7:0]  ch;
        logic        last;
        logic [15:0] line;
        logic [15:0] col;
    } stt_tok_t;

    typedef struct packed {
        logic       latch;
        logic       exec;
        logic       rd;
        logic [1:0] load;
        logic       fin;
    } stt_cmd_t;

    typedef struct packed {
        logic run_v;
        logic a_v;
        logic b_v;
        logic run_last;
        logic out_free;
    } stt_stat_t;

    // Reserved words, right aligned, first character in the highest used byte.
    localparam logic [63:0] KW_TEXT [NUM_KW] = '{
        64'("and"), 64'("array"), 64'("begin"), 64'("boolean"), 64'("call"),
        64'("do"), 64'("else"), 64'("elsif"), 64'("end"), 64'("false"),
        64'("function"), 64'("get"), 64'("if"), 64'("integer"), 64'("leave"),
        64'("not"), 64'("or"), 64'("put"), 64'("relax"), 64'("rem"),
        64'("source"), 64'("string"), 64'("then"), 64'("to"), 64'("true"),
        64'("while")
    };

    localparam logic [5:0] KW_LEN [NUM_KW] = '{
        6'd3, 6'd5, 6'd5, 6'd7, 6'd4, 6'd2, 6'd4, 6'd5, 6'd3, 6'd5,
        6'd8, 6'd3, 6'd2, 6'd7, 6'd5, 6'd3, 6'd2, 6'd3, 6'd5, 6'd3,
        6'd6, 6'd6, 6'd4, 6'd2, 6'd4, 6'd5
    };

endpackage

// File: rtl/stt_datapath.sv
// ----------------------------------------------------------------------------
// Source text tokenizer datapath
// Scanner state, lexeme memory, keyword match and the output register.
// ----------------------------------------------------------------------------
module stt_datapath import stt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  stt_cmd_t    cmd,
    output stt_stat_t   stat,
    input  logic [7:0]  in_char,
    input  logic        in_eoi,
    output logic        m_valid,
    input  logic        m_ready,
    output stt_tok_t    m_tok
);

    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_WORD    = 3'd1;
    localparam logic [2:0] M_NUMBER  = 3'd2;
    localparam logic [2:0] M_STRING  = 3'd3;
    localparam logic [2:0] M_ESCAPE  = 3'd4;
    localparam logic [2:0] M_COMMENT = 3'd5;
    localparam logic [2:0] M_OPHELD  = 3'd6;
    localparam logic [2:0] M_HALT    = 3'd7;

    logic [7:0]  c_reg;
    logic        eoi_reg;
    logic [2:0]  mode_reg, mode_next;
    logic [7:0]  held_reg, held_next;
    logic [5:0]  len_reg, len_next;
    logic [30:0] acc_reg, acc_next;
    logic [4:0]  depth_reg, depth_next;
    logic [15:0] line_reg, line_next;
    logic [15:0] col_reg, col_next;
    logic        anl_reg, anl_next;
    logic [15:0] sl_reg, sl_next;
    logic [15:0] sc_reg, sc_next;
    logic        wr_en_reg, wr_en_next;
    logic [4:0]  wr_addr_reg, wr_addr_next;
    logic        run_v_reg, run_v_next;
    logic        a_v_reg, a_v_next;
    logic        b_v_reg, b_v_next;
    stt_tok_t    tok_a_reg, tok_a_next;
    stt_tok_t    tok_b_reg, tok_b_next;
    stt_tok_t    run_tok_reg;
    stt_tok_t    run_out;
    logic [5:0]  run_len_reg;
    logic [5:0]  idx_reg;
    logic [7:0]  rdata_reg;
    logic [7:0]  pre_reg [8];
    logic [7:0]  lex_mem [STORE_DEPTH];
    logic        m_valid_reg;
    stt_tok_t    m_tok_reg;

    logic [15:0] lc1, cc0, cc1, bcol;
    logic        is_letter, is_digit, word_ch, follow;
    logic [34:0] num_v;
    logic        kw_hit;
    logic [5:0]  kw_kind;
    logic        out_free;

    function automatic stt_tok_t mk_tok(input logic [5:0] kind, input logic [3:0] err,
                                        input logic [30:0] num, input logic [7:0] ch,
                                        input logic last, input logic [15:0] line,
                                        input logic [15:0] col);
        stt_tok_t t;
        t.kind = kind;
        t.err  = err;
        t.num  = num;
        t.ch   = ch;
        t.last = last;
        t.line = line;
        t.col  = col;
        return t;
    endfunction

    function automatic logic [5:0] single_op(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h2A:   k = K_STAR;
            8'h2B:   k = K_PLUS;
            8'h2C:   k = K_COMMA;
            8'h2D:   k = K_MINUS;
            8'h2E:   k = K_DOT;
            8'h2F:   k = K_SLASH;
            8'h3B:   k = K_SEMI;
            8'h3D:   k = K_EQ;
            8'h5B:   k = K_LBRACK;
            8'h5D:   k = K_RBRACK;
            default: k = 6'd0;
        endcase
        return k;
    endfunction

    // Keyword match against the first eight stored characters.
    always_comb begin
        logic m;
        int   pos;
        kw_hit  = 1'b0;
        kw_kind = K_KW_BASE;
        for (int i = NUM_KW - 1; i >= 0; i--) begin
            m = (len_reg == KW_LEN[i]);
            for (int j = 0; j < 8; j++) begin
                pos = 8 * (int'(KW_LEN[i]) - 1 - j);
                if (j < int'(KW_LEN[i])) begin
                    if (pre_reg[j] != KW_TEXT[i][pos +: 8]) begin
                        m = 1'b0;
                    end
                end
            end
            if (m) begin
                kw_hit  = 1'b1;
                kw_kind = K_KW_BASE + 6'(i);
            end
        end
    end

    assign lc1       = (anl_reg && line_reg != 16'hFFFF) ? line_reg + 16'd1 : line_reg;
    assign cc0       = anl_reg ? 16'd0 : col_reg;
    assign cc1       = (cc0 != 16'hFFFF) ? cc0 + 16'd1 : cc0;
    assign bcol      = cc1 - 16'd1;
    assign is_letter = (c_reg >= 8'h41 && c_reg <= 8'h5A) || (c_reg >= 8'h61 && c_reg <= 8'h7A);
    assign is_digit  = (c_reg >= 8'h30 && c_reg <= 8'h39);
    assign word_ch   = is_letter || is_digit || c_reg == 8'h5F;
    assign num_v     = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                     + {31'd0, c_reg[3:0] - 4'd0};

    always_comb begin
        logic [5:0] k;
        logic [4:0] dd;
        mode_next    = mode_reg;
        held_next    = held_reg;
        len_next     = len_reg;
        acc_next     = acc_reg;
        depth_next   = depth_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        anl_next     = anl_reg;
        sl_next      = sl_reg;
        sc_next      = sc_reg;
        wr_en_next   = 1'b0;
        wr_addr_next = len_reg[4:0];
        run_v_next   = 1'b0;
        a_v_next     = 1'b0;
        b_v_next     = 1'b0;
        tok_a_next   = '0;
        tok_b_next   = '0;
        follow       = 1'b0;
        k            = '0;
        dd           = '0;
        if (mode_reg != M_HALT) begin
            line_next = lc1;
            col_next  = cc1;
            anl_next  = !eoi_reg && c_reg == 8'h0A;
            unique case (mode_reg)
                M_IDLE: begin
                    follow = 1'b1;
                end
                M_WORD: begin
                    if (!eoi_reg && word_ch) begin
                        if (len_reg >= 6'(ID_LIMIT)) begin
                            a_v_next   = 1'b1;
                            tok_a_next = mk_tok(K_ERROR, E_IDLONG, '0, '0, 1'b1, sl_reg, sc_reg);
                            mode_next  = M_HALT;
                        end else begin
                            wr_en_next = 1'b1;
                            len_next   = len_reg + 6'd1;
                        end
                    end else begin
                        if (kw_hit) begin
                            a_v_next   = 1'b1;
                            tok_a_next = mk_tok(kw_kind, E_NONE, '0, '0, 1'b1, sl_reg, sc_reg);
                        end else begin
                            run_v_next = 1'b1;
                        end
                        len_next = '0;
                        follow   = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (!eoi_reg && is_digit) begin
                        if (num_v[34:31] != 4'd0) begin
                            a_v_next   = 1'b1;
                            tok_a_next = mk_tok(K_ERROR, E_NUMBER, '0, '0, 1'b1, sl_reg, sc_reg);
                            mode_next  = M_HALT;
                        end else begin
                            acc_next = num_v[30:0];
                        end
                    end else begin
                        a_v_next   = 1'b1;
                        tok_a_next = mk_tok(K_NUMBER, E_NONE, acc_reg, '0, 1'b1, sl_reg, sc_reg);
                        acc_next   = '0;
                        follow     = 1'b1;
                    end
                end
                M_STRING: begin
                    a_v_next = 1'b1;
                    if (eoi_reg) begin
                        tok_a_next = mk_tok(K_ERROR, E_STROPEN, '0, '0, 1'b1, sl_reg, sc_reg);
                        mode_next  = M_HALT;
                    end else if (c_reg < 8'h20 || c_reg > 8'h7E) begin
                        tok_a_next = mk_tok(K_ERROR, E_NONPRT, '0, '0, 1'b1, lc1, cc1);
                        mode_next  = M_HALT;
                    end else if (c_reg == 8'h22) begin
                        tok_a_next = mk_tok(K_STRING, E_NONE, '0,
                                            (len_reg != 6'd0) ? held_reg : 8'h00, 1'b1,
                                            sl_reg, sc_reg);
                        len_next   = '0;
                        mode_next  = M_IDLE;
                    end else begin
                        a_v_next   = (len_reg != 6'd0);
                        tok_a_next = mk_tok(K_STRING, E_NONE, '0, held_reg, 1'b0, sl_reg, sc_reg);
                        held_next  = c_reg;
                        len_next   = 6'd1;
                        if (c_reg == 8'h5C) begin
                            mode_next = M_ESCAPE;
                        end
                    end
                end
                M_ESCAPE: begin
                    a_v_next = 1'b1;
                    if (!eoi_reg && (c_reg == 8'h6E || c_reg == 8'h74 ||
                                     c_reg == 8'h22 || c_reg == 8'h5C)) begin
                        tok_a_next = mk_tok(K_STRING, E_NONE, '0, held_reg, 1'b0, sl_reg, sc_reg);
                        held_next  = c_reg;
                        len_next   = 6'd1;
                        mode_next  = M_STRING;
                    end else begin
                        tok_a_next = mk_tok(K_ERROR, E_ESCAPE, '0, '0, 1'b1, lc1, bcol);
                        mode_next  = M_HALT;
                    end
                end
                M_COMMENT: begin
                    if (eoi_reg) begin
                        a_v_next   = 1'b1;
                        tok_a_next = mk_tok(K_ERROR, E_COMOPEN, '0, '0, 1'b1, sl_reg, sc_reg);
                        mode_next  = M_HALT;
                    end else if (c_reg == 8'h7B) begin
                        if (depth_reg >= 5'(COMMENT_DEPTH_MAX)) begin
                            a_v_next   = 1'b1;
                            tok_a_next = mk_tok(K_ERROR, E_NESTING, '0, '0, 1'b1, lc1, cc1);
                            mode_next  = M_HALT;
                        end else begin
                            depth_next = depth_reg + 5'd1;
                        end
                    end else if (c_reg == 8'h7D) begin
                        dd         = (depth_reg != 5'd0) ? depth_reg - 5'd1 : 5'd0;
                        depth_next = dd;
                        if (dd == 5'd0) begin
                            mode_next = M_IDLE;
                        end
                    end
                end
                M_OPHELD: begin
                    a_v_next  = 1'b1;
                    mode_next = M_IDLE;
                    if (held_reg == 8'h3A) begin
                        if (!eoi_reg && c_reg == 8'h3D) begin
                            tok_a_next = mk_tok(K_BECOMES, E_NONE, '0, '0, 1'b1, sl_reg, sc_reg);
                        end else begin
                            tok_a_next = mk_tok(K_ERROR, E_ILLEGAL, '0, '0, 1'b1, sl_reg, sc_reg);
                            mode_next  = M_HALT;
                        end
                    end else if (!eoi_reg && c_reg == 8'h3D) begin
                        tok_a_next = mk_tok((held_reg == 8'h3C) ? K_LE : K_GE, E_NONE, '0, '0,
                                            1'b1, sl_reg, sc_reg);
                    end else if (!eoi_reg && c_reg == 8'h3E && held_reg == 8'h3C) begin
                        tok_a_next = mk_tok(K_NE, E_NONE, '0, '0, 1'b1, sl_reg, sc_reg);
                    end else begin
                        tok_a_next = mk_tok((held_reg == 8'h3C) ? K_LT : K_GT, E_NONE, '0, '0,
                                            1'b1, sl_reg, sc_reg);
                        follow     = 1'b1;
                    end
                end
                default: begin
                    mode_next = M_HALT;
                end
            endcase

            // Handling of the current byte as the first byte after a token.
            if (follow) begin
                if (eoi_reg) begin
                    b_v_next   = 1'b1;
                    tok_b_next = mk_tok(K_EOF, E_NONE, '0, '0, 1'b1, lc1, cc1);
                    mode_next  = M_HALT;
                end else begin
                    mode_next = M_IDLE;
                    if (c_reg == 8'h20 || c_reg == 8'h09 || c_reg == 8'h0A) begin
                        mode_next = M_IDLE;
                    end else if (is_letter || c_reg == 8'h5F) begin
                        sl_next      = lc1;
                        sc_next      = cc1;
                        wr_en_next   = 1'b1;
                        wr_addr_next = '0;
                        len_next     = 6'd1;
                        mode_next    = M_WORD;
                    end else if (is_digit) begin
                        sl_next   = lc1;
                        sc_next   = cc1;
                        acc_next  = {27'd0, c_reg[3:0]};
                        mode_next = M_NUMBER;
                    end else if (c_reg == 8'h22) begin
                        sl_next   = lc1;
                        sc_next   = cc1;
                        len_next  = '0;
                        mode_next = M_STRING;
                    end else if (c_reg == 8'h7B) begin
                        sl_next    = lc1;
                        sc_next    = cc1;
                        depth_next = 5'd1;
                        mode_next  = M_COMMENT;
                    end else if (c_reg == 8'h3A || c_reg == 8'h3C || c_reg == 8'h3E) begin
                        sl_next   = lc1;
                        sc_next   = cc1;
                        held_next = c_reg;
                        mode_next = M_OPHELD;
                    end else begin
                        k        = single_op(c_reg);
                        b_v_next = 1'b1;
                        if (k != 6'd0) begin
                            tok_b_next = mk_tok(k, E_NONE, '0, '0, 1'b1, lc1, cc1);
                        end else begin
                            tok_b_next = mk_tok(K_ERROR, E_ILLEGAL, '0, '0, 1'b1, lc1, cc1);
                            mode_next  = M_HALT;
                        end
                    end
                end
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    // One character of an identifier run, as it goes to the output register.
    always_comb begin
        run_out      = run_tok_reg;
        run_out.ch   = rdata_reg;
        run_out.last = stat.run_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= M_IDLE;
            held_reg    <= '0;
            len_reg     <= '0;
            acc_reg     <= '0;
            depth_reg   <= '0;
            line_reg    <= 16'd1;
            col_reg     <= '0;
            anl_reg     <= 1'b0;
            sl_reg      <= 16'd1;
            sc_reg      <= '0;
            wr_en_reg   <= 1'b0;
            run_v_reg   <= 1'b0;
            a_v_reg     <= 1'b0;
            b_v_reg     <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                pre_reg[i] <= '0;
            end
        end else begin
            if (cmd.exec) begin
                mode_reg    <= mode_next;
                held_reg    <= held_next;
                len_reg     <= len_next;
                acc_reg     <= acc_next;
                depth_reg   <= depth_next;
                line_reg    <= line_next;
                col_reg     <= col_next;
                anl_reg     <= anl_next;
                sl_reg      <= sl_next;
                sc_reg      <= sc_next;
                wr_en_reg   <= wr_en_next;
                run_v_reg   <= run_v_next;
                a_v_reg     <= a_v_next;
                b_v_reg     <= b_v_next;
                idx_reg     <= '0;
            end
            if (cmd.load == LD_RUN) begin
                idx_reg <= idx_reg + 6'd1;
            end
            if (cmd.fin) begin
                wr_en_reg <= 1'b0;
                if (wr_en_reg && wr_addr_reg < 5'd8) begin
                    pre_reg[wr_addr_reg[2:0]] <= c_reg;
                end
            end
            if (cmd.load != LD_NONE) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            c_reg   <= in_char;
            eoi_reg <= in_eoi;
        end
        if (cmd.exec) begin
            wr_addr_reg <= wr_addr_next;
            tok_a_reg   <= tok_a_next;
            tok_b_reg   <= tok_b_next;
            run_len_reg <= len_reg;
            run_tok_reg <= mk_tok(K_IDENT, E_NONE, '0, '0, 1'b0, sl_reg, sc_reg);
        end
        unique case (cmd.load)
            LD_RUN:  m_tok_reg <= run_out;
            LD_A:    m_tok_reg <= tok_a_reg;
            LD_B:    m_tok_reg <= tok_b_reg;
            default: m_tok_reg <= m_tok_reg;
        endcase
    end

    // Lexeme memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.fin && wr_en_reg) begin
            lex_mem[wr_addr_reg] <= c_reg;
        end
        if (cmd.rd) begin
            rdata_reg <= lex_mem[idx_reg[4:0]];
        end
    end

    assign stat.run_v    = run_v_reg;
    assign stat.a_v      = a_v_reg;
    assign stat.b_v      = b_v_reg;
    assign stat.run_last = (idx_reg + 6'd1 == run_len_reg);
    assign stat.out_free = out_free;
    assign m_valid       = m_valid_reg;
    assign m_tok         = m_tok_reg;

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load != LD_NONE) |-> out_free)
        else $error("result loaded over an untaken result");
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= 5'(COMMENT_DEPTH_MAX))
        else $error("comment depth beyond limit");
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= 6'(ID_LIMIT))
        else $error("lexeme length beyond limit");

endmodule

// File: rtl/stt_ctrl.sv
// ----------------------------------------------------------------------------
// Source text tokenizer controller
// Sequences accept, scan step, result transfers and the lexeme write.
// ----------------------------------------------------------------------------
module stt_ctrl import stt_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  stt_stat_t stat,
    output stt_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_DISP   = 3'd2;
    localparam logic [2:0] S_RUN_RD = 3'd3;
    localparam logic [2:0] S_RUN_TX = 3'd4;
    localparam logic [2:0] S_TOKA   = 3'd5;
    localparam logic [2:0] S_TOKB   = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    logic [2:0] state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.latch = s_valid;
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_DISP;
            end
            S_DISP: begin
                state_next = stat.run_v ? S_RUN_RD : S_TOKA;
            end
            S_RUN_RD: begin
                cmd.rd     = 1'b1;
                state_next = S_RUN_TX;
            end
            S_RUN_TX: begin
                if (stat.out_free) begin
                    cmd.load   = LD_RUN;
                    state_next = stat.run_last ? S_TOKA : S_RUN_RD;
                end
            end
            S_TOKA: begin
                if (!stat.a_v) begin
                    state_next = S_TOKB;
                end else if (stat.out_free) begin
                    cmd.load   = LD_A;
                    state_next = S_TOKB;
                end
            end
            S_TOKB: begin
                if (!stat.b_v) begin
                    state_next = S_FIN;
                end else if (stat.out_free) begin
                    cmd.load   = LD_B;
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                cmd.fin    = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // A run character always waits for its memory read in between.
    a_one_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load == LD_RUN) |=> (cmd.load != LD_RUN))
        else $error("run characters loaded in consecutive cycles");
    a_exec_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> cmd.exec)
        else $error("scan step did not follow an accepted byte");

endmodule

// File: rtl/source_text_tokenizer_top.sv
// ----------------------------------------------------------------------------
// Source text tokenizer
// Turns a stream of source bytes into a stream of tokens.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  tdata                          tuser       tlast
//  s_axis    in         [7:0] input_char               -           end_of_input
//  m_axis    out        [3:0] error, [34:4] value,     [5:0] kind  last_of_run
//                       [42:35] char, [58:43] line,
//                       [74:59] col
//
//  Each byte passes through the accept, the scan step, a dispatch step, a
//  step for each of the two token slots, used or not, and a finishing step
//  that writes the lexeme memory. An identifier run adds a read step and a
//  transfer step per character, as the lexeme memory read port is registered.
//  Reset is synchronous and active low; the lexeme memory is not cleared.
//  A stalled result holds the block at its next result transfer; a new byte
//  is taken only after every result of the previous byte is loaded.
//  After an error or end-of-input token the block accepts bytes and drops
//  them until reset.
//
module source_text_tokenizer_top import stt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] input_char
    input  logic        s_axis_tlast,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // error, value, char, line, column
    output logic [5:0]  m_axis_tuser,   // [5:0] kind
    output logic        m_axis_tlast    // last_of_run
);

    stt_cmd_t  cmd;
    stt_stat_t stat;
    stt_tok_t  tok;

    // The controller decides when a transfer happens; the datapath holds
    // the scanner state and the output register.
    stt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    stt_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .in_char (s_axis_tdata),
        .in_eoi  (s_axis_tlast),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_tok   (tok)
    );

    // Fields packed from the lowest bit up, zero filled to whole bytes.
    // The token kind says what the transfer carries, so it travels as tuser.
    assign m_axis_tdata = {5'd0, tok.col, tok.line, tok.ch, tok.num, tok.err};
    assign m_axis_tuser = tok.kind;
    assign m_axis_tlast = tok.last;

endmodule

// File: tb/sv/tb_source_text_tokenizer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer stream checker
// Watches both channels, predicts the token stream from the accepted bytes
// and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module tb_source_text_tokenizer_checker import stt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [79:0] m_axis_tdata,
    input  logic [5:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          tokens_pending,
    output int          tokens_checked
);

    localparam logic [5:0] K_NONE   = 6'd0;
    localparam logic [30:0] NUM_LIMIT = 31'h7FFF_FFFF;

    typedef enum logic [2:0] {
        SC_IDLE, SC_WORD, SC_NUMBER, SC_STRING, SC_ESCAPE, SC_COMMENT, SC_OPHELD, SC_HALT
    } scan_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [3:0]  err;
        logic [30:0] num;
        logic [7:0]  ch;
        logic        last;
        logic [15:0] line;
        logic [15:0] col;
    } token_t;

    string reserved_words[26] = '{
        "and", "array", "begin", "boolean", "call", "do", "else", "elsif", "end",
        "false", "function", "get", "if", "integer", "leave", "not", "or", "put",
        "relax", "rem", "source", "string", "then", "to", "true", "while"
    };

    token_t      token_q[$];
    scan_t       scan;
    logic [7:0]  held;
    logic [7:0]  lexeme[32];
    int unsigned lex_len;
    logic [30:0] accum;
    int unsigned depth;
    logic [15:0] line_no, col_no, tok_line, tok_col;
    logic        newline_seen;

    assign tokens_pending = token_q.size();

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [5:0] single_op_kind(logic [7:0] c);
        case (c)
            "(": return K_LPAREN;
            ")": return K_RPAREN;
            "*": return K_STAR;
            "+": return K_PLUS;
            ",": return K_COMMA;
            "-": return K_MINUS;
            ".": return K_DOT;
            "/": return K_SLASH;
            ";": return K_SEMI;
            "=": return K_EQ;
            "[": return K_LBRACK;
            "]": return K_RBRACK;
            default: return K_NONE;
        endcase
    endfunction

    function automatic void push_token(logic [5:0] kind, logic [3:0] err, logic [30:0] num,
                                       logic [7:0] ch, logic last, logic [15:0] ln,
                                       logic [15:0] cl);
        token_q.push_back('{kind, err, num, ch, last, ln, cl});
    endfunction

    function automatic void raise_error(logic [3:0] code, logic [15:0] ln, logic [15:0] cl);
        push_token(K_ERROR, code, '0, '0, 1'b1, ln, cl);
        scan = SC_HALT;
    endfunction

    function automatic void emit_eof();
        push_token(K_EOF, E_NONE, '0, '0, 1'b1, line_no, col_no);
        scan = SC_HALT;
    endfunction

    // A finished word is either a reserved word (one token) or an identifier run.
    function automatic void emit_word();
        bit same;
        for (int k = 0; k < 26; k++) begin
            same = (reserved_words[k].len() == lex_len);
            for (int i = 0; i < lex_len && same; i++) begin
                if (reserved_words[k][i] != lexeme[i]) same = 1'b0;
            end
            if (same) begin
                push_token(K_KW_BASE + 6'(k), E_NONE, '0, '0, 1'b1, tok_line, tok_col);
                lex_len = 0;
                return;
            end
        end
        for (int i = 0; i < lex_len; i++)
            push_token(K_IDENT, E_NONE, '0, lexeme[i], i + 1 == lex_len, tok_line, tok_col);
        lex_len = 0;
    endfunction

    function automatic void start_token();
        tok_line = line_no;
        tok_col  = col_no;
    endfunction

    function automatic void scan_idle(logic [7:0] c);
        logic [5:0] k;
        scan = SC_IDLE;
        if (c == " " || c == 8'h09 || c == 8'h0A) return;
        if (is_letter(c) || c == "_") begin
            start_token();
            lexeme[0] = c;
            lex_len = 1;
            scan = SC_WORD;
        end else if (is_digit(c)) begin
            start_token();
            accum = 31'(c - 8'd48);
            scan = SC_NUMBER;
        end else if (c == "\"") begin
            start_token();
            lex_len = 0;
            scan = SC_STRING;
        end else if (c == "{") begin
            start_token();
            depth = 1;
            scan = SC_COMMENT;
        end else if (c == ":" || c == "<" || c == ">") begin
            start_token();
            held = c;
            scan = SC_OPHELD;
        end else begin
            k = single_op_kind(c);
            if (k != K_NONE) push_token(k, E_NONE, '0, '0, 1'b1, line_no, col_no);
            else raise_error(E_ILLEGAL, line_no, col_no);
        end
    endfunction

    function automatic void predict_byte(logic [7:0] c, logic eoi);
        logic [63:0] grown;
        logic [15:0] prev_col;
        if (scan == SC_HALT) return;
        if (newline_seen) begin
            if (line_no != 16'hFFFF) line_no++;
            col_no = 0;
        end
        if (col_no != 16'hFFFF) col_no++;
        newline_seen = !eoi && c == 8'h0A;
        prev_col = col_no - 16'd1;
        case (scan)
            SC_IDLE: begin
                if (eoi) emit_eof();
                else scan_idle(c);
            end
            SC_WORD: begin
                if (!eoi && (is_letter(c) || is_digit(c) || c == "_")) begin
                    if (lex_len >= ID_LIMIT) raise_error(E_IDLONG, tok_line, tok_col);
                    else begin
                        lexeme[lex_len] = c;
                        lex_len++;
                    end
                end else begin
                    emit_word();
                    if (eoi) emit_eof();
                    else scan_idle(c);
                end
            end
            SC_NUMBER: begin
                if (!eoi && is_digit(c)) begin
                    grown = 64'(accum) * 10 + 64'(c - 8'd48);
                    if (grown > 64'(NUM_LIMIT)) raise_error(E_NUMBER, tok_line, tok_col);
                    else accum = 31'(grown);
                end else begin
                    push_token(K_NUMBER, E_NONE, accum, '0, 1'b1, tok_line, tok_col);
                    accum = 0;
                    if (eoi) emit_eof();
                    else scan_idle(c);
                end
            end
            SC_STRING: begin
                if (eoi) raise_error(E_STROPEN, tok_line, tok_col);
                else if (c < 8'h20 || c > 8'h7E) raise_error(E_NONPRT, line_no, col_no);
                else if (c == "\"") begin
                    // The character held back is the last one of the run.
                    push_token(K_STRING, E_NONE, '0, lex_len != 0 ? held : 8'h00, 1'b1,
                               tok_line, tok_col);
                    lex_len = 0;
                    scan = SC_IDLE;
                end else begin
                    if (lex_len != 0)
                        push_token(K_STRING, E_NONE, '0, held, 1'b0, tok_line, tok_col);
                    held = c;
                    lex_len = 1;
                    if (c == "\\") scan = SC_ESCAPE;
                end
            end
            SC_ESCAPE: begin
                if (!eoi && (c == "n" || c == "t" || c == "\"" || c == "\\")) begin
                    push_token(K_STRING, E_NONE, '0, held, 1'b0, tok_line, tok_col);
                    held = c;
                    lex_len = 1;
                    scan = SC_STRING;
                end else begin
                    raise_error(E_ESCAPE, line_no, prev_col);
                end
            end
            SC_COMMENT: begin
                if (eoi) raise_error(E_COMOPEN, tok_line, tok_col);
                else if (c == "{") begin
                    if (depth >= COMMENT_DEPTH_MAX) raise_error(E_NESTING, line_no, col_no);
                    else depth++;
                end else if (c == "}") begin
                    if (depth > 0) depth--;
                    if (depth == 0) scan = SC_IDLE;
                end
            end
            SC_OPHELD: begin
                if (held == ":") begin
                    if (!eoi && c == "=") begin
                        push_token(K_BECOMES, E_NONE, '0, '0, 1'b1, tok_line, tok_col);
                        scan = SC_IDLE;
                    end else begin
                        raise_error(E_ILLEGAL, tok_line, tok_col);
                    end
                end else if (!eoi && c == "=") begin
                    push_token(held == "<" ? K_LE : K_GE, E_NONE, '0, '0, 1'b1,
                               tok_line, tok_col);
                    scan = SC_IDLE;
                end else if (!eoi && c == ">" && held == "<") begin
                    push_token(K_NE, E_NONE, '0, '0, 1'b1, tok_line, tok_col);
                    scan = SC_IDLE;
                end else begin
                    push_token(held == "<" ? K_LT : K_GT, E_NONE, '0, '0, 1'b1,
                               tok_line, tok_col);
                    if (eoi) emit_eof();
                    else scan_idle(c);
                end
            end
            default: scan = SC_HALT;
        endcase
    endfunction

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Both channels are sampled at the rising edge, before any register updates.
    always @(posedge aclk) begin
        token_t want;
        if (!aresetn) begin
            token_q.delete();
            scan = SC_IDLE;
            held = 0;
            lex_len = 0;
            accum = 0;
            depth = 0;
            line_no = 1;
            col_no = 0;
            newline_seen = 0;
            tok_line = 1;
            tok_col = 0;
            fail_count = 0;
            tokens_checked = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                tokens_checked++;
                if (token_q.size() == 0) begin
                    $error("unexpected token transfer: kind %0d", m_axis_tuser);
                    fail_count++;
                end else begin
                    want = token_q.pop_front();
                    check_field("token_kind",   want.kind, m_axis_tuser);
                    check_field("error_code",   want.err,  m_axis_tdata[3:0]);
                    check_field("number_value", want.num,  m_axis_tdata[34:4]);
                    check_field("text_char",    want.ch,   m_axis_tdata[42:35]);
                    check_field("last_of_run",  want.last, m_axis_tlast);
                    check_field("token_line",   want.line, m_axis_tdata[58:43]);
                    check_field("token_column", want.col,  m_axis_tdata[74:59]);
                end
            end
        end
    end

endmodule

// File: tb/sv/tb_source_text_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer testbench top
// Feeds one long source text through the tokenizer, with random idle bursts
// on both channels, and ends it with an end mark or one randomly chosen error.
// ----------------------------------------------------------------------------
module tb_source_text_tokenizer_top;
    import stt_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] input_char
    logic        s_axis_tlast;   // end_of_input
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;   // error, value, char, line, column
    logic [5:0]  m_axis_tuser;   // [5:0] kind
    logic        m_axis_tlast;   // last_of_run

    int fail_count, tokens_pending, tokens_checked;
    int bytes_sent;
    int cycle_count = 0;
    bit quiet;       // When set, neither side inserts idle cycles.
    bit hold_req;    // Asks the receiver for one long stall.
    bit hold_done;   // The long receiver stall has been requested.
    bit pause_done;  // The sender has drained the block once.
    byte unsigned src_q[$];

    string reserved_words[26] = '{
        "and", "array", "begin", "boolean", "call", "do", "else", "elsif", "end",
        "false", "function", "get", "if", "integer", "leave", "not", "or", "put",
        "relax", "rem", "source", "string", "then", "to", "true", "while"
    };
    string operators[18] = '{
        "(", ")", "*", "+", ",", "-", ".", "/", ":=", ";", "<", "<=", "<>", "=",
        ">", ">=", "[", "]"
    };

    source_text_tokenizer_top i_dut (.*);

    tb_source_text_tokenizer_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // The run is bounded by a cycle budget far beyond the slowest correct run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > 400000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random stalls, one long stall on request, and none at the end.
    initial begin
        m_axis_tready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // One byte transfer. The ready is looked at on the falling edge, so the
    // rising edge that follows is the one that takes the byte.
    task automatic send_byte(byte unsigned c, bit eoi);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eoi;
        @(negedge aclk);
        while (!s_axis_tready) @(negedge aclk);
        @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic flush_text();
        while (src_q.size() != 0) send_byte(src_q.pop_front(), 1'b0);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) src_q.push_back(s[i]);
    endtask

    task automatic add_gap();
        byte unsigned ws[3] = '{8'h20, 8'h09, 8'h0A};
        repeat ($urandom_range(1, 3)) src_q.push_back(ws[$urandom_range(0, 2)]);
    endtask

    function automatic byte unsigned word_char(bit first);
        int r;
        r = $urandom_range(0, first ? 52 : 62);
        if (r < 26) return 8'(int'("a") + r);
        if (r < 52) return 8'(int'("A") + r - 26);
        if (r == 52) return "_";
        return 8'(int'("0") + r - 53);
    endfunction

    task automatic add_ident(int len);
        src_q.push_back(word_char(1));
        repeat (len - 1) src_q.push_back(word_char(0));
    endtask

    task automatic add_number();
        int unsigned v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 99);
            1: v = 2147483647;
            default: v = $urandom_range(0, 2147483647);
        endcase
        add_text($sformatf("%0d", v));
    endtask

    // Printable content with escapes; quote and backslash only inside escapes.
    task automatic add_string();
        string escapes = "nt\"\\";
        byte unsigned c;
        src_q.push_back("\"");
        repeat ($urandom_range(0, 10)) begin
            if ($urandom_range(0, 4) == 0) begin
                src_q.push_back("\\");
                src_q.push_back(escapes[$urandom_range(0, 3)]);
            end else begin
                do c = $urandom_range(8'h20, 8'h7E); while (c == "\"" || c == "\\");
                src_q.push_back(c);
            end
        end
        src_q.push_back("\"");
    endtask

    // Comment bodies carry arbitrary bytes, so every input bit is exercised.
    task automatic add_comment(int levels);
        byte unsigned c;
        repeat (levels) src_q.push_back("{");
        repeat ($urandom_range(0, 6)) begin
            do c = $urandom_range(0, 255); while (c == "{" || c == "}");
            src_q.push_back(c);
        end
        repeat (levels) src_q.push_back("}");
    endtask

    // The error that ends the text; every error halts the block for good.
    task automatic add_ending();
        case ($urandom_range(0, 9))
            0: add_text("a # b");
            1: add_text("2147483648");
            2: add_ident(ID_LIMIT + 1);
            3: add_text("\"abc");
            4: begin add_text("\"ab"); src_q.push_back(8'h7F); end
            5: add_text("\"a\\q\"");
            6: add_text("\"x\\");
            7: add_text("{ open { }");
            8: add_comment(COMMENT_DEPTH_MAX + 1);
            default: add_text("x : y");
        endcase
    endtask

    initial begin
        string kw_line;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        aresetn <= 1'b0;
        quiet = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        pause_done = 1'b0;
        bytes_sent = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed text: fused operators, the equals sign before '<' and '>',
        // reserved words against case, both string edge cases, number limit,
        // the longest identifier and a nested comment.
        add_text("x:=10;a<=b<>c>=d=<e=>f<g>h\n");
        add_text("begin BEGIN string \"\" \"a\\n\\t\\\"\\\\~ \" ");
        add_text("2147483647 0 {{ } }\t");
        add_ident(ID_LIMIT);
        add_text("\n");
        flush_text();

        // Random text; the middle of it holds both pressure points.
        while (bytes_sent < 300) begin
            if (bytes_sent > 80 && !hold_done) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
                while (hold_req) begin
                    case ($urandom_range(0, 1))
                        0: add_text(operators[$urandom_range(0, 17)]);
                        default: add_number();
                    endcase
                    add_gap();
                    flush_text();
                end
            end
            if (bytes_sent > 150 && !pause_done) begin
                pause_done = 1'b1;
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
                while (tokens_pending != 0) @(posedge aclk);
            end
            quiet = bytes_sent > 250;
            case ($urandom_range(0, 6))
                0: add_text(reserved_words[$urandom_range(0, 25)]);
                1: add_ident($urandom_range(0, 9) == 0 ? ID_LIMIT : $urandom_range(1, 8));
                2: add_number();
                3: add_string();
                4: add_comment($urandom_range(0, 4) == 0 ?
                               COMMENT_DEPTH_MAX : $urandom_range(1, 3));
                default: add_text(operators[$urandom_range(0, 17)]);
            endcase
            add_gap();
            flush_text();
        end

        // Close the text with either the end mark or one error, then send a
        // few bytes that the halted block must drop.
        if ($urandom_range(0, 1) == 0) send_byte($urandom_range(0, 255), 1'b1);
        else begin
            add_ending();
            flush_text();
            send_byte($urandom_range(0, 255), 1'b1);
        end
        repeat (3) send_byte($urandom_range(0, 255), $urandom_range(0, 1));
        s_axis_tvalid <= 1'b0;

        while (tokens_pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("Sent %0d source bytes: words, numbers, strings, comments and operators,",
                 bytes_sent);
        $display("closed by an end mark or an error; %0d token transfers checked.",
                 tokens_checked);
        if (fail_count == 0 && tokens_pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
